>>> design/gpr_pkg.sv
// Shared types, constants and helper functions for the GPIO port register block.
package gpr_pkg;

  localparam int unsigned PIN_COUNT = 16;
  localparam logic [15:0] PIN_MASK  = 16'((32'd1 << PIN_COUNT) - 32'd1);

  typedef enum logic [3:0] {
    REG_MODE     = 4'd0,
    REG_OTYPE    = 4'd1,
    REG_SPEED    = 4'd2,
    REG_PULL     = 4'd3,
    REG_INPUT    = 4'd4,
    REG_OUTPUT   = 4'd5,
    REG_SETRESET = 4'd6,
    REG_LOCK     = 4'd7,
    REG_AFL      = 4'd8,
    REG_AFH      = 4'd9
  } gpr_reg_t;

  typedef enum logic [1:0] {
    KEY_IDLE      = 2'd0,
    KEY_ARMED     = 2'd1,
    KEY_CONFIRMED = 2'd2
  } gpr_key_t;

  typedef struct packed {
    logic        done;
    logic [15:0] pins;
  } gpr_lock_t;

  // Widens each pin bit to a two-bit field.
  function automatic logic [31:0] spread2(input logic [15:0] pins);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i +: 2] = {2{pins[i]}};
    end
    return r;
  endfunction

  // Widens each of eight pin bits to a four-bit field.
  function automatic logic [31:0] spread4(input logic [7:0] pins);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{pins[i]}};
    end
    return r;
  endfunction

  // Frozen bits keep their old value; bits of absent pins read as zero.
  function automatic logic [31:0] guarded(input logic [31:0] old_val,
                                          input logic [31:0] data,
                                          input logic [31:0] frozen,
                                          input logic [31:0] valid);
    return ((old_val & frozen) | (data & ~frozen)) & valid;
  endfunction

endpackage

>>> design/gpr_if.sv
// Channel interfaces for the access beats and the result beats.
interface gpr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  reg_index;
  logic [31:0] write_data;
  logic [15:0] pin_levels;

  modport source (output valid, output cmd, output reg_index, output write_data,
                  output pin_levels, input ready);
  modport sink   (input valid, input cmd, input reg_index, input write_data,
                  input pin_levels, output ready);
endinterface

interface gpr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [15:0] pin_drive;
  logic        lock_active;

  modport source (output valid, output read_data, output pin_drive,
                  output lock_active, input ready);
  modport sink   (input valid, input read_data, input pin_drive,
                  input lock_active, output ready);
endinterface

>>> design/gpr_lock.sv
// Lock key sequence tracker and the frozen-pin register.
module gpr_lock
  import gpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [16:0] wr_data,
  output gpr_lock_t   lock_cur,
  output gpr_lock_t   lock_nxt
);

  gpr_key_t    step_r, step_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic        done_r;
  logic [15:0] pins_r;
  logic        key;
  logic        match;
  logic        complete;

  assign key   = wr_data[16];
  assign match = (wr_data[15:0] == mask_r);

  // Next state. An unmatched write is judged again as a first step.
  always_comb begin
    step_nxt = step_r;
    mask_nxt = mask_r;
    if (wr_en && !done_r) begin
      case (step_r)
        KEY_ARMED: begin
          if (!key && match) begin
            step_nxt = KEY_CONFIRMED;
          end else if (key) begin
            step_nxt = KEY_ARMED;
            mask_nxt = wr_data[15:0];
          end else begin
            step_nxt = KEY_IDLE;
          end
        end
        KEY_CONFIRMED: begin
          if (key && match) begin
            step_nxt = KEY_IDLE;
          end else if (key) begin
            step_nxt = KEY_ARMED;
            mask_nxt = wr_data[15:0];
          end else begin
            step_nxt = KEY_IDLE;
          end
        end
        default: begin
          if (key) begin
            step_nxt = KEY_ARMED;
            mask_nxt = wr_data[15:0];
          end else begin
            step_nxt = KEY_IDLE;
          end
        end
      endcase
    end
  end

  // Outputs of the sequence: the lock closes on the matching third write.
  always_comb begin
    complete = wr_en && !done_r && (step_r == KEY_CONFIRMED) && key && match;
    lock_cur = '{done: done_r, pins: pins_r};
    if (complete) begin
      lock_nxt = '{done: 1'b1, pins: mask_r & PIN_MASK};
    end else begin
      lock_nxt = lock_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= KEY_IDLE;
      mask_r <= '0;
      done_r <= 1'b0;
      pins_r <= '0;
    end else begin
      step_r <= step_nxt;
      mask_r <= mask_nxt;
      done_r <= lock_nxt.done;
      pins_r <= lock_nxt.pins;
    end
  end

endmodule

>>> design/gpio_port_registers.sv
// Top level of the sixteen-pin GPIO port register block.
//
// One access beat enters on in_ch: a read or write command, a register
// index, a write data word and the sampled pin levels. Each access gives
// exactly one result beat on out_ch with the read data (zero for writes),
// the output data driven to the pins and the lock status, all as they stand
// after the access.
//
// The register update and the result are formed in the cycle the access
// beat is taken and the result is held in an output register, so the result
// is valid in the cycle after acceptance. One access is taken every cycle while
// the receiver keeps up; the single output register sets that rate.
// When the receiver stalls, the result waits in the output register and
// in_ch.ready drops until it is taken, so no access is taken whose result
// could not be held.
// Synchronous reset clears every port register, the lock and the key
// sequence, and empties the output register. Once the lock key sequence
// completes, the configuration bits of the locked pins hold until reset.
module gpio_port_registers
  import gpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gpr_in_if.sink     in_ch,
  gpr_out_if.source  out_ch
);

  logic [31:0] mode_r, mode_nxt;
  logic [15:0] otype_r, otype_nxt;
  logic [31:0] speed_r, speed_nxt;
  logic [31:0] pull_r, pull_nxt;
  logic [15:0] odata_r, odata_nxt;
  logic [31:0] afl_r, afl_nxt;
  logic [31:0] afh_r, afh_nxt;

  logic        out_valid_r;
  logic [31:0] rdata_r, rdata_nxt;
  logic [15:0] drive_r;
  logic        lock_act_r;

  logic        accept;
  logic        wr;
  logic        lock_wr;
  gpr_lock_t   lock_cur;
  gpr_lock_t   lock_nxt;
  logic [31:0] frozen2;
  logic [31:0] frozen4l;
  logic [31:0] frozen4h;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign wr          = accept && in_ch.cmd;
  assign lock_wr     = wr && (in_ch.reg_index == REG_LOCK);

  gpr_lock u_lock (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (lock_wr),
    .wr_data  (in_ch.write_data[16:0]),
    .lock_cur (lock_cur),
    .lock_nxt (lock_nxt)
  );

  assign frozen2  = spread2(lock_cur.pins);
  assign frozen4l = spread4(lock_cur.pins[7:0]);
  assign frozen4h = spread4(lock_cur.pins[15:8]);

  always_comb begin
    mode_nxt  = mode_r;
    otype_nxt = otype_r;
    speed_nxt = speed_r;
    pull_nxt  = pull_r;
    odata_nxt = odata_r;
    afl_nxt   = afl_r;
    afh_nxt   = afh_r;
    if (wr) begin
      case (in_ch.reg_index)
        REG_MODE:  mode_nxt  = guarded(mode_r, in_ch.write_data, frozen2,
                                       spread2(PIN_MASK));
        REG_OTYPE: otype_nxt = 16'(guarded({16'd0, otype_r}, in_ch.write_data,
                                           {16'd0, lock_cur.pins},
                                           {16'd0, PIN_MASK}));
        REG_SPEED: speed_nxt = guarded(speed_r, in_ch.write_data, frozen2,
                                       spread2(PIN_MASK));
        REG_PULL:  pull_nxt  = guarded(pull_r, in_ch.write_data, frozen2,
                                       spread2(PIN_MASK));
        REG_OUTPUT: odata_nxt = in_ch.write_data[15:0] & PIN_MASK;
        // Clear first, then set, so set wins where both name a pin.
        REG_SETRESET: odata_nxt = ((odata_r & ~in_ch.write_data[31:16])
                                   | in_ch.write_data[15:0]) & PIN_MASK;
        REG_AFL:   afl_nxt   = guarded(afl_r, in_ch.write_data, frozen4l,
                                       spread4(PIN_MASK[7:0]));
        REG_AFH:   afh_nxt   = guarded(afh_r, in_ch.write_data, frozen4h,
                                       spread4(PIN_MASK[15:8]));
        default: ;
      endcase
    end
  end

  always_comb begin
    rdata_nxt = '0;
    if (!in_ch.cmd) begin
      case (in_ch.reg_index)
        REG_MODE:   rdata_nxt = mode_r;
        REG_OTYPE:  rdata_nxt = {16'd0, otype_r};
        REG_SPEED:  rdata_nxt = speed_r;
        REG_PULL:   rdata_nxt = pull_r;
        REG_INPUT:  rdata_nxt = {16'd0, in_ch.pin_levels & PIN_MASK};
        REG_OUTPUT: rdata_nxt = {16'd0, odata_r};
        REG_LOCK:   rdata_nxt = {15'd0, lock_cur.done, lock_cur.pins};
        REG_AFL:    rdata_nxt = afl_r;
        REG_AFH:    rdata_nxt = afh_r;
        default:    rdata_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      otype_r <= '0;
      speed_r <= '0;
      pull_r  <= '0;
      odata_r <= '0;
      afl_r   <= '0;
      afh_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      otype_r <= otype_nxt;
      speed_r <= speed_nxt;
      pull_r  <= pull_nxt;
      odata_r <= odata_nxt;
      afl_r   <= afl_nxt;
      afh_r   <= afh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r    <= rdata_nxt;
      drive_r    <= odata_nxt;
      lock_act_r <= lock_nxt.done;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = rdata_r;
  assign out_ch.pin_drive   = drive_r;
  assign out_ch.lock_active = lock_act_r;

  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    lock_cur.done |=> lock_cur.done)
    else $error("lock released without reset");

  a_lock_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
    lock_cur.done |=> $stable(lock_cur.pins))
    else $error("locked pin set changed after lock");

  a_mode_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    lock_cur.done |=> ((mode_r ^ $past(mode_r)) & spread2(lock_cur.pins)) == 32'd0)
    else $error("mode bits of a locked pin changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("access refused with the output register empty");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the GPIO port register block, lock sequence included.
`timescale 1ns / 1ps

module tb
  import gpr_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   sent_count;
  int   cycle_count;

  gpr_in_if  in_ch ();
  gpr_out_if out_ch ();

  gpio_port_registers i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic        lock_active;
  } port_result_t;

  // Shadow copy of the port registers and the queue of results still owed.
  class port_scoreboard;
    logic [31:0]  mode_q, speed_q, pull_q, afl_q, afh_q;
    logic [15:0]  otype_q, drive_q, frozen_q, key_pins_q;
    logic         lock_set_q;
    gpr_key_t     key_state_q;
    port_result_t owed_q[$];
    int           fail_count;

    function new();
      mode_q      = '0;
      speed_q     = '0;
      pull_q      = '0;
      afl_q       = '0;
      afh_q       = '0;
      otype_q     = '0;
      drive_q     = '0;
      frozen_q    = '0;
      key_pins_q  = '0;
      lock_set_q  = 1'b0;
      key_state_q = KEY_IDLE;
      fail_count  = 0;
    endfunction

    // Each pin bit from 'first' onwards becomes a field of 'width' bits.
    function logic [31:0] widen(logic [15:0] pins, int first, int width);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 32 / width; i++) begin
        if (pins[first + i]) begin
          r |= ((width == 2) ? 32'h3 : 32'hF) << (i * width);
        end
      end
      return r;
    endfunction

    function logic [31:0] merge(logic [31:0] old_word, logic [31:0] data,
                                logic [31:0] frozen, logic [31:0] present);
      return ((old_word & frozen) | (data & ~frozen)) & present;
    endfunction

    function void lock_key_write(logic [31:0] data);
      logic        key;
      logic [15:0] m;
      key = data[16];
      m   = data[15:0];
      if (lock_set_q) begin
        return;
      end
      if (key_state_q == KEY_ARMED && !key && m == key_pins_q) begin
        key_state_q = KEY_CONFIRMED;
      end else if (key_state_q == KEY_CONFIRMED && key && m == key_pins_q) begin
        lock_set_q  = 1'b1;
        frozen_q    = key_pins_q & PIN_MASK;
        key_state_q = KEY_IDLE;
      end else if (key) begin
        key_state_q = KEY_ARMED;
        key_pins_q  = m;
      end else begin
        key_state_q = KEY_IDLE;
      end
    endfunction

    function void note_access(logic c, logic [3:0] idx, logic [31:0] d, logic [15:0] lv);
      port_result_t r;
      r.read_data = '0;
      if (c) begin
        case (idx)
          REG_MODE:     mode_q  = merge(mode_q, d, widen(frozen_q, 0, 2), widen(PIN_MASK, 0, 2));
          REG_OTYPE:    otype_q = 16'(merge(32'(otype_q), d, 32'(frozen_q), 32'(PIN_MASK)));
          REG_SPEED:    speed_q = merge(speed_q, d, widen(frozen_q, 0, 2), widen(PIN_MASK, 0, 2));
          REG_PULL:     pull_q  = merge(pull_q, d, widen(frozen_q, 0, 2), widen(PIN_MASK, 0, 2));
          REG_OUTPUT:   drive_q = d[15:0] & PIN_MASK;
          REG_SETRESET: drive_q = ((drive_q & ~d[31:16]) | d[15:0]) & PIN_MASK;
          REG_LOCK:     lock_key_write(d);
          REG_AFL:      afl_q   = merge(afl_q, d, widen(frozen_q, 0, 4), widen(PIN_MASK, 0, 4));
          REG_AFH:      afh_q   = merge(afh_q, d, widen(frozen_q, 8, 4), widen(PIN_MASK, 8, 4));
          default: ;
        endcase
      end else begin
        case (idx)
          REG_MODE:   r.read_data = mode_q;
          REG_OTYPE:  r.read_data = {16'h0, otype_q};
          REG_SPEED:  r.read_data = speed_q;
          REG_PULL:   r.read_data = pull_q;
          REG_INPUT:  r.read_data = {16'h0, lv & PIN_MASK};
          REG_OUTPUT: r.read_data = {16'h0, drive_q};
          REG_LOCK:   r.read_data = {15'h0, lock_set_q, frozen_q};
          REG_AFL:    r.read_data = afl_q;
          REG_AFH:    r.read_data = afh_q;
          default:    r.read_data = '0;
        endcase
      end
      r.pin_drive   = drive_q;
      r.lock_active = lock_set_q;
      owed_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (fail_count < 40) begin
        $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      end
      fail_count++;
    endtask

    task check_result(logic [31:0] rd, logic [15:0] drive, logic lock);
      port_result_t want;
      if (owed_q.size() == 0) begin
        report("unexpected result beat", rd, '0);
        return;
      end
      want = owed_q.pop_front();
      if (rd !== want.read_data) report("read_data", rd, want.read_data);
      if (drive !== want.pin_drive) report("pin_drive", 32'(drive), 32'(want.pin_drive));
      if (lock !== want.lock_active) report("lock_active", 32'(lock), 32'(want.lock_active));
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  port_scoreboard sb = new();

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gpio_port_registers test failed");
      $finish;
    end
  end

  // Both channels are sampled before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_access(in_ch.cmd, in_ch.reg_index, in_ch.write_data, in_ch.pin_levels);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.read_data, out_ch.pin_drive, out_ch.lock_active);
      end
    end
  end

  // Result side: ready drops in bursts whose frequency follows the idle level.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance of the beat.
  task automatic send_access(input logic c, input logic [3:0] idx,
                             input logic [31:0] d, input logic [15:0] lv);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd        <= c;
    in_ch.reg_index  <= idx;
    in_ch.write_data <= d;
    in_ch.pin_levels <= lv;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'hFFFF_0000;
      3:       return 32'h0000_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_levels();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] lock_word(logic key, logic [15:0] m);
    return {15'($urandom), key, m};
  endfunction

  task automatic random_access();
    logic [3:0] idx;
    if ($urandom_range(0, 99) < 85) idx = 4'($urandom_range(0, 9));
    else idx = 4'($urandom_range(10, 15));
    send_access(1'($urandom_range(0, 1)), idx, pick_word(), pick_levels());
  endtask

  // Accesses to any register but the lock leave the key sequence where it is.
  task automatic non_lock_accesses();
    logic [3:0] idx;
    repeat ($urandom_range(0, 3)) begin
      do idx = 4'($urandom_range(0, 15)); while (idx == REG_LOCK);
      send_access(1'($urandom_range(0, 1)), idx, pick_word(), pick_levels());
    end
  endtask

  // A key sequence that either completes or is spoilt at its second or third step.
  task automatic key_attempt(input bit complete);
    logic [15:0] m;
    int          spoil_at;
    logic [15:0] flip;
    case ($urandom_range(0, 5))
      0:       m = '0;
      1:       m = '1;
      default: m = 16'($urandom);
    endcase
    spoil_at = complete ? 0 : $urandom_range(2, 3);
    flip     = 16'($urandom_range(1, 65535));
    send_access(1'b1, REG_LOCK, lock_word(1'b1, m), pick_levels());
    non_lock_accesses();
    if (spoil_at == 2) begin
      if ($urandom_range(0, 1) == 0) send_access(1'b1, REG_LOCK, lock_word(1'b1, m), pick_levels());
      else send_access(1'b1, REG_LOCK, lock_word(1'b0, m ^ flip), pick_levels());
      return;
    end
    send_access(1'b1, REG_LOCK, lock_word(1'b0, m), pick_levels());
    non_lock_accesses();
    if (spoil_at == 3) begin
      if ($urandom_range(0, 1) == 0) send_access(1'b1, REG_LOCK, lock_word(1'b0, m), pick_levels());
      else send_access(1'b1, REG_LOCK, lock_word(1'b1, m ^ flip), pick_levels());
    end else begin
      send_access(1'b1, REG_LOCK, lock_word(1'b1, m), pick_levels());
    end
  endtask

  task automatic random_phase(input int upto, input bit with_keys);
    while (sent_count < upto) begin
      if (sent_count % 100 < 2) begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 25;
          default: idle_pct = 50;
        endcase
      end
      if (with_keys && $urandom_range(0, 99) < 25) key_attempt(1'b0);
      else random_access();
    end
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    idle_pct         = 0;
    sent_count       = 0;
    cycle_count      = 0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = 1'b0;
    in_ch.reg_index  = '0;
    in_ch.write_data = '0;
    in_ch.pin_levels = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Accesses to every register, set and clear naming the same pins, input
    // reads, unmapped indexes and key sequences that break off.
    send_access(1'b0, REG_MODE,     '0,             16'hFFFF);
    send_access(1'b1, REG_MODE,     '1,             '0);
    send_access(1'b0, REG_MODE,     '0,             '0);
    send_access(1'b1, REG_OTYPE,    '1,             '0);
    send_access(1'b0, REG_OTYPE,    '0,             '0);
    send_access(1'b1, REG_SPEED,    32'hAAAA_5555,  '0);
    send_access(1'b1, REG_PULL,     32'h5555_AAAA,  '0);
    send_access(1'b0, REG_PULL,     '0,             '0);
    send_access(1'b1, REG_AFL,      '1,             '0);
    send_access(1'b1, REG_AFH,      32'h1234_5678,  '0);
    send_access(1'b0, REG_AFH,      '0,             '0);
    send_access(1'b0, REG_INPUT,    '0,             16'hFFFF);
    send_access(1'b1, REG_INPUT,    '1,             16'hA5A5);
    send_access(1'b1, REG_OUTPUT,   '1,             '0);
    send_access(1'b1, REG_SETRESET, 32'hFFFF_0000,  '0);
    send_access(1'b1, REG_SETRESET, 32'h00FF_00FF,  '0);
    send_access(1'b0, REG_SETRESET, '0,             '0);
    send_access(1'b1, REG_LOCK,     32'h0001_00F0,  '0);
    send_access(1'b1, REG_LOCK,     32'hFFFE_00F0,  '0);
    send_access(1'b1, REG_LOCK,     32'h0001_000F,  '0);
    send_access(1'b1, REG_LOCK,     32'h0000_0F00,  '0);
    send_access(1'b0, REG_LOCK,     '0,             '0);
    send_access(1'b1, 4'd15,        '1,             '0);
    send_access(1'b0, 4'd10,        '0,             16'hFFFF);
    send_access(1'b0, 4'd15,        '0,             16'hFFFF);
    drain_results();

    random_phase(900, 1'b1);

    // Lock the port once, with nothing in flight, then keep hammering it.
    idle_pct = 10;
    drain_results();
    key_attempt(1'b1);
    send_access(1'b0, REG_LOCK, '0, '0);
    random_phase(1300, 1'b1);

    idle_pct = 0;
    while (sent_count < 1470) random_access();

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("gpio_port_registers test passed");
    end else begin
      $display("gpio_port_registers test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/gpr_pkg.sv
design/gpr_if.sv
design/gpr_lock.sv
design/gpio_port_registers.sv
tb/tb.sv
